[hw/rtl/soaa_pkg.sv]
`default_nettype none
package soaa_pkg;

    localparam int unsigned POS_W   = 24;
    localparam int unsigned RAD_W   = 14;
    localparam int unsigned ELEM_W  = 3;
    localparam int unsigned NORM_W  = 24;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned RAW_W   = 40;
    localparam int unsigned OUTN_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;

    // shared divider geometry
    localparam int unsigned DIV_Q_W    = 64;
    localparam int unsigned DIV_D_W    = 25;
    localparam int unsigned DIV_STEP_W = 6;

    // integer square root geometry
    localparam int unsigned SQ_IN_W   = 50;
    localparam int unsigned SQ_OUT_W  = 25;
    localparam int unsigned SQ_CNT_W  = 5;

    localparam logic [17:0] PI_Q16     = 18'd205887;
    localparam logic [19:0] FOUR_PI_Q16 = 20'd823548;

    localparam logic [ELEM_W-1:0] ELEM_C = 3'd1;
    localparam logic [ELEM_W-1:0] ELEM_O = 3'd2;
    localparam logic [ELEM_W-1:0] ELEM_N = 3'd3;
    localparam logic [ELEM_W-1:0] ELEM_S = 3'd4;
    localparam logic [ELEM_W-1:0] ELEM_P = 3'd5;
    localparam logic [ELEM_W-1:0] ELEM_H = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_C = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_O = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_N = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_S = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_P = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_H = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NORM     = 3'd6;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

endpackage
`default_nettype wire

[hw/rtl/soaa_divider.sv]
`default_nettype none
module soaa_divider (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire soaa_pkg::div_req_t                req,
    input  wire logic [soaa_pkg::DIV_D_W-1:0]      r_init,
    input  wire logic [soaa_pkg::DIV_Q_W-1:0]      q_init,
    input  wire logic [soaa_pkg::DIV_D_W-1:0]      divisor,
    output logic [soaa_pkg::DIV_Q_W-1:0]           quotient,
    output logic                                   done
);
    logic [soaa_pkg::DIV_D_W-1:0]    rem_reg;
    logic [soaa_pkg::DIV_Q_W-1:0]    q_reg;
    logic [soaa_pkg::DIV_D_W-1:0]    d_reg;
    logic [soaa_pkg::DIV_STEP_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [soaa_pkg::DIV_D_W:0] shifted;
    logic [soaa_pkg::DIV_D_W:0] trial;
    logic                       fits;

    assign shifted = {rem_reg, q_reg[soaa_pkg::DIV_Q_W-1]};
    assign trial   = shifted - {1'b0, d_reg};
    assign fits    = shifted >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= r_init;
                q_reg    <= q_init;
                d_reg    <= divisor;
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // one restoring step per cycle
                if (fits)
                begin
                    rem_reg <= trial[soaa_pkg::DIV_D_W-1:0];
                    q_reg   <= {q_reg[soaa_pkg::DIV_Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[soaa_pkg::DIV_D_W-1:0];
                    q_reg   <= {q_reg[soaa_pkg::DIV_Q_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == soaa_pkg::DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

[hw/rtl/soaa_sqrt.sv]
`default_nettype none
module soaa_sqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [soaa_pkg::SQ_IN_W-1:0]    radicand,
    output logic [soaa_pkg::SQ_OUT_W-1:0]        root,
    output logic                                 done
);
    localparam int unsigned REM_W = soaa_pkg::SQ_OUT_W + 1;

    logic [soaa_pkg::SQ_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [soaa_pkg::SQ_OUT_W-1:0] root_reg;
    logic [soaa_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             fits;

    assign rem2  = {rem_reg, rad_reg[soaa_pkg::SQ_IN_W-1 -: 2]};
    assign trial = (REM_W + 2)'({root_reg, 2'b01});
    assign fits  = rem2 >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= soaa_pkg::SQ_CNT_W'(soaa_pkg::SQ_OUT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // two radicand bits per cycle
                rad_reg <= {rad_reg[soaa_pkg::SQ_IN_W-3:0], 2'b00};
                if (fits)
                begin
                    rem_reg  <= REM_W'(rem2 - trial);
                    root_reg <= {root_reg[soaa_pkg::SQ_OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= REM_W'(rem2);
                    root_reg <= {root_reg[soaa_pkg::SQ_OUT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == soaa_pkg::SQ_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

[hw/rtl/sphere_overlap_area_accumulator.sv]
`default_nettype none
// Sphere overlap area accumulator. One atom pair is taken per transfer on the in channel; the
// block is busy until that pair is folded into the running sum. A pair is skipped, found not
// to touch, found nested, or worked as a cap pair: one shared 32x32 multiplier is stepped
// through the squares and products, a radix-4 square root takes 25 steps and a shared
// restoring divider takes 40 steps for the cap area. A last pair adds the 32-step normalising
// division before the result is loaded into the output register, or skips it when the
// quotient saturates; the next pair is taken while that result waits on the out channel.
// Configuration writes are always ready and take effect at once.
module sphere_overlap_area_accumulator #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [soaa_pkg::POS_W-1:0]   pos_a_x,
    input  wire logic signed [soaa_pkg::POS_W-1:0]   pos_a_y,
    input  wire logic signed [soaa_pkg::POS_W-1:0]   pos_a_z,
    input  wire logic signed [soaa_pkg::POS_W-1:0]   pos_b_x,
    input  wire logic signed [soaa_pkg::POS_W-1:0]   pos_b_y,
    input  wire logic signed [soaa_pkg::POS_W-1:0]   pos_b_z,
    input  wire logic [soaa_pkg::ELEM_W-1:0]         element_a,
    input  wire logic [soaa_pkg::ELEM_W-1:0]         element_b,
    input  wire logic [soaa_pkg::RAD_W-1:0]          override_a,
    input  wire logic [soaa_pkg::RAD_W-1:0]          override_b,
    input  wire logic                                same_atom,
    input  wire logic                                last_pair,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [soaa_pkg::RAW_W-1:0]               raw_area_sum,
    output logic [soaa_pkg::OUTN_W-1:0]              normalised_overlap,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [soaa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [soaa_pkg::CFG_DAT_W-1:0]      cfg_data
);
    localparam longint SCALE   = longint'(1) << FRAC_BITS;
    localparam longint RC_RAW  = (170 * SCALE + 50) / 100;
    localparam longint RO_RAW  = (152 * SCALE + 50) / 100;
    localparam longint RN_RAW  = (155 * SCALE + 50) / 100;
    localparam longint RS_RAW  = (180 * SCALE + 50) / 100;
    localparam longint RH_RAW  = (109 * SCALE + 50) / 100;
    localparam longint RAD_MAX = 16383;
    localparam logic [13:0] RC_RST = 14'(RC_RAW > RAD_MAX ? RAD_MAX : RC_RAW);
    localparam logic [13:0] RO_RST = 14'(RO_RAW > RAD_MAX ? RAD_MAX : RO_RAW);
    localparam logic [13:0] RN_RST = 14'(RN_RAW > RAD_MAX ? RAD_MAX : RN_RAW);
    localparam logic [13:0] RS_RST = 14'(RS_RAW > RAD_MAX ? RAD_MAX : RS_RAW);
    localparam logic [13:0] RH_RST = 14'(RH_RAW > RAD_MAX ? RAD_MAX : RH_RAW);
    localparam longint NORM_RAW = FRAC_BITS >= 12 ? (longint'(148760) << (FRAC_BITS - 12))
                                                  : (longint'(148760) >> (12 - FRAC_BITS));
    localparam logic [23:0] NORM_RST = 24'(NORM_RAW);
    localparam int AREA_SHIFT = 16 + FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_DX, S_DY, S_DZ, S_SUMSQ, S_DIFSQ, S_TEST, S_RR, S_FP, S_FS,
        S_SQ_START, S_SQ_WAIT, S_T2, S_RB2, S_NCHK, S_RP, S_RPN, S_DV_START, S_DV_WAIT,
        S_ACC, S_NM_START, S_NM_WAIT, S_EMIT
    } state_t;

    state_t state_reg;

    logic [13:0] rad_c_reg, rad_o_reg, rad_n_reg, rad_s_reg, rad_p_reg, rad_h_reg;
    logic [23:0] norm_reg;

    logic [13:0] ra_reg, rb_reg;
    logic [24:0] dx_reg, dy_reg, dz_reg;
    logic        last_reg;
    logic [49:0] s_reg;
    logic [63:0] prod_reg;
    logic        contact_reg;
    logic [49:0] tsq_reg;
    logic [24:0] d_reg;
    logic [27:0] n_reg;
    logic [47:0] area_reg;
    logic [47:0] sum_reg;
    logic [31:0] nres_reg;
    logic        out_valid_reg;
    logic [39:0] raw_out_reg;
    logic [31:0] norm_out_reg;

    // radius select
    function automatic logic [13:0] pick(input logic [2:0] elem, input logic [13:0] ovr,
                                         input logic [13:0] rc, input logic [13:0] ro,
                                         input logic [13:0] rn, input logic [13:0] rs,
                                         input logic [13:0] rp, input logic [13:0] rh);
        logic [13:0] r;
        r = '0;
        if (ovr != '0)
            r = ovr;
        else
        begin
            case (elem)
                soaa_pkg::ELEM_C: r = rc;
                soaa_pkg::ELEM_O: r = ro;
                soaa_pkg::ELEM_N: r = rn;
                soaa_pkg::ELEM_S: r = rs;
                soaa_pkg::ELEM_P: r = rp;
                soaa_pkg::ELEM_H: r = rh;
                default:          r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [24:0] absdiff(input logic signed [23:0] a,
                                            input logic signed [23:0] b);
        logic signed [24:0] d;
        d = 25'(a) - 25'(b);
        return d[24] ? 25'(-d) : 25'(d);
    endfunction

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [14:0] rsum;
    logic [13:0] rdiff;
    logic [13:0] rmin;
    logic signed [25:0] t_val;
    logic [24:0] t_abs;

    assign rsum  = {1'b0, ra_reg} + {1'b0, rb_reg};
    assign rdiff = (ra_reg > rb_reg) ? (ra_reg - rb_reg) : (rb_reg - ra_reg);
    assign rmin  = (ra_reg < rb_reg) ? ra_reg : rb_reg;
    assign t_val = $signed({1'b0, d_reg}) - $signed({12'b0, ra_reg});
    assign t_abs = t_val[25] ? 25'(-t_val) : t_val[24:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DX:    begin mul_a = 32'(dx_reg);        mul_b = 32'(dx_reg); end
            S_DY:    begin mul_a = 32'(dy_reg);        mul_b = 32'(dy_reg); end
            S_DZ:    begin mul_a = 32'(dz_reg);        mul_b = 32'(dz_reg); end
            S_SUMSQ: begin mul_a = 32'(rsum);          mul_b = 32'(rsum); end
            S_DIFSQ: begin mul_a = 32'(rdiff);         mul_b = 32'(rdiff); end
            S_RR:    begin mul_a = 32'(rmin);          mul_b = 32'(rmin); end
            S_FP:    begin mul_a = 32'(prod_reg[27:0]); mul_b = 32'(soaa_pkg::FOUR_PI_Q16); end
            S_T2:    begin mul_a = 32'(t_abs);         mul_b = 32'(t_abs); end
            S_RB2:   begin mul_a = 32'(rb_reg);        mul_b = 32'(rb_reg); end
            S_RP:    begin mul_a = 32'(ra_reg);        mul_b = 32'(soaa_pkg::PI_Q16); end
            S_RPN:   begin mul_a = prod_reg[31:0];     mul_b = 32'(n_reg); end
            default: begin mul_a = '0;                 mul_b = '0; end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // square root and divider
    logic [24:0] sq_root;
    logic        sq_done;

    soaa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQ_START),
        .radicand (s_reg),
        .root     (sq_root),
        .done     (sq_done)
    );

    logic                norm_sat;
    soaa_pkg::div_req_t  div_req;
    logic [24:0]         div_r_init;
    logic [63:0]         div_q_init;
    logic [24:0]         div_divisor;
    logic [63:0]         div_quot;
    logic                div_done;
    logic [63:0]         cap_num;

    assign norm_sat = (norm_reg == '0) || (sum_reg >= {norm_reg, 16'b0});
    assign cap_num  = prod_reg >> AREA_SHIFT;

    always_comb
    begin
        div_req     = '0;
        div_r_init  = '0;
        div_q_init  = '0;
        div_divisor = d_reg;
        if (state_reg == S_DV_START)
        begin
            div_req.start = 1'b1;
            div_req.steps = soaa_pkg::DIV_STEP_W'(40);
            div_q_init    = {cap_num[39:0], 24'b0};
        end
        else if (state_reg == S_NM_START)
        begin
            div_req.start = !norm_sat;
            div_req.steps = soaa_pkg::DIV_STEP_W'(32);
            div_r_init    = sum_reg[40:16];
            div_q_init    = {sum_reg[15:0], 48'b0};
            div_divisor   = {1'b0, norm_reg};
        end
    end

    soaa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .r_init   (div_r_init),
        .q_init   (div_q_init),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    logic [48:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + {1'b0, area_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rad_c_reg     <= RC_RST;
            rad_o_reg     <= RO_RST;
            rad_n_reg     <= RN_RST;
            rad_s_reg     <= RS_RST;
            rad_p_reg     <= RS_RST;
            rad_h_reg     <= RH_RST;
            norm_reg      <= NORM_RST;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    soaa_pkg::REG_RADIUS_C: rad_c_reg <= cfg_data[13:0];
                    soaa_pkg::REG_RADIUS_O: rad_o_reg <= cfg_data[13:0];
                    soaa_pkg::REG_RADIUS_N: rad_n_reg <= cfg_data[13:0];
                    soaa_pkg::REG_RADIUS_S: rad_s_reg <= cfg_data[13:0];
                    soaa_pkg::REG_RADIUS_P: rad_p_reg <= cfg_data[13:0];
                    soaa_pkg::REG_RADIUS_H: rad_h_reg <= cfg_data[13:0];
                    soaa_pkg::REG_NORM:     norm_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ra_reg   <= pick(element_a, override_a, rad_c_reg, rad_o_reg,
                                         rad_n_reg, rad_s_reg, rad_p_reg, rad_h_reg);
                        rb_reg   <= pick(element_b, override_b, rad_c_reg, rad_o_reg,
                                         rad_n_reg, rad_s_reg, rad_p_reg, rad_h_reg);
                        dx_reg   <= absdiff(pos_a_x, pos_b_x);
                        dy_reg   <= absdiff(pos_a_y, pos_b_y);
                        dz_reg   <= absdiff(pos_a_z, pos_b_z);
                        last_reg <= last_pair;
                        area_reg <= '0;
                        state_reg <= same_atom ? S_ACC : S_DX;
                    end
                end
                S_DX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    s_reg     <= prod_reg[49:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_DZ;
                end
                S_DZ:
                begin
                    s_reg     <= s_reg + prod_reg[49:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_SUMSQ;
                end
                S_SUMSQ:
                begin
                    s_reg     <= s_reg + prod_reg[49:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_DIFSQ;
                end
                S_DIFSQ:
                begin
                    contact_reg <= prod_reg > 64'(s_reg);
                    prod_reg    <= mul_p;
                    state_reg   <= S_TEST;
                end
                S_TEST:
                begin
                    if (!contact_reg)
                        state_reg <= S_ACC;
                    else if (prod_reg > 64'(s_reg) || s_reg == '0)
                        state_reg <= S_RR;
                    else
                        state_reg <= S_SQ_START;
                end
                S_RR:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_FP;
                end
                S_FP:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_FS;
                end
                S_FS:
                begin
                    area_reg  <= 48'(prod_reg >> AREA_SHIFT);
                    state_reg <= S_ACC;
                end
                S_SQ_START:
                begin
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT:
                begin
                    if (sq_done)
                    begin
                        d_reg     <= sq_root;
                        state_reg <= S_T2;
                    end
                end
                S_T2:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_RB2;
                end
                S_RB2:
                begin
                    tsq_reg   <= prod_reg[49:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_NCHK;
                end
                S_NCHK:
                begin
                    // cap height not positive: nothing buried
                    if (64'(tsq_reg) >= prod_reg)
                        state_reg <= S_ACC;
                    else
                    begin
                        n_reg     <= 28'(prod_reg - 64'(tsq_reg));
                        state_reg <= S_RP;
                    end
                end
                S_RP:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_RPN;
                end
                S_RPN:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DV_START;
                end
                S_DV_START:
                begin
                    state_reg <= S_DV_WAIT;
                end
                S_DV_WAIT:
                begin
                    if (div_done)
                    begin
                        area_reg  <= 48'(div_quot[39:0]);
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    sum_reg   <= sum_add[48] ? '1 : sum_add[47:0];
                    state_reg <= last_reg ? S_NM_START : S_IDLE;
                end
                S_NM_START:
                begin
                    if (norm_sat)
                    begin
                        nres_reg  <= '1;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_NM_WAIT;
                end
                S_NM_WAIT:
                begin
                    if (div_done)
                    begin
                        nres_reg  <= div_quot[31:0];
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        raw_out_reg   <= (sum_reg[47:40] != '0) ? '1 : sum_reg[39:0];
                        norm_out_reg  <= nres_reg;
                        out_valid_reg <= 1'b1;
                        sum_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready           = (state_reg == S_IDLE);
    assign cfg_ready          = 1'b1;
    assign out_valid          = out_valid_reg;
    assign raw_area_sum       = raw_out_reg;
    assign normalised_overlap = norm_out_reg;
endmodule
`default_nettype wire

[hw/rtl/soaa_checker.sv]
`default_nettype none
module soaa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [39:0] raw_area_sum,
    input wire logic [31:0] normalised_overlap
);
    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_area_sum)
                                    && $stable(normalised_overlap))
        else $error("result changed while stalled");

    // a pair keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a pair");

    // a new result is loaded only from a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");
endmodule

bind sphere_overlap_area_accumulator soaa_checker u_soaa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .raw_area_sum       (raw_area_sum),
    .normalised_overlap (normalised_overlap)
);
`default_nettype wire
